@@ rtl/mmcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_pkg
// Shared types and fixed constants of the min/max/mean column decimator.
// ----------------------------------------------------------------------------
package mmcd_pkg;

	localparam int FIELD_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int SHIFT_W     = 5;
	localparam int DIM_W       = 13;
	localparam int ROW_W       = 13;
	localparam int COL_IDX_W   = 12;
	localparam int COL_CNT_W   = 13;
	localparam int ROW_SEL_W   = 3;
	localparam int Q_W         = 14;

	localparam int MIN_VIEW_WIDTH  = 50;
	localparam int MIN_VIEW_HEIGHT = 16;
	localparam int MAX_VIEW_HEIGHT = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SHIFT,
		CFG_VIEW_HEIGHT,
		CFG_VIEW_WIDTH,
		CFG_STEREO_MODE
	} cfg_reg_t;

	typedef enum logic [ROW_SEL_W-1:0] {
		ROW_L_LO,
		ROW_L_HI,
		ROW_L_MEAN,
		ROW_R_LO,
		ROW_R_HI,
		ROW_R_MEAN
	} row_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_L_GO,
		ST_DIV_L_WAIT,
		ST_DIV_R_GO,
		ST_DIV_R_WAIT,
		ST_ROWS,
		ST_DRAIN,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     div_start;
		logic     div_right;
		logic     row_issue;
		row_sel_t row_sel;
		logic     load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic take_close;
		logic div_done;
		logic row_busy;
		logic out_free;
		logic stereo;
	} ctrl_sts_t;

endpackage

@@ rtl/mmcd_smp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_smp_if
// Sample channel: one left/right sample pair and its last flag.
// ----------------------------------------------------------------------------
interface mmcd_smp_if;
	import mmcd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] left_sample;
	logic signed [FIELD_W-1:0] right_sample;
	logic                      last_sample;

	modport source (output valid, left_sample, right_sample, last_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, last_sample, output ready);

endinterface

@@ rtl/mmcd_col_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_col_if
// Column channel: the display rows of one decimated column.
// ----------------------------------------------------------------------------
interface mmcd_col_if;
	import mmcd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [COL_IDX_W-1:0] column_index;
	logic [ROW_W-1:0]     left_low_row;
	logic [ROW_W-1:0]     left_high_row;
	logic [ROW_W-1:0]     left_mean_row;
	logic [ROW_W-1:0]     right_low_row;
	logic [ROW_W-1:0]     right_high_row;
	logic [ROW_W-1:0]     right_mean_row;

	modport source (output valid, column_index, left_low_row, left_high_row, left_mean_row,
		right_low_row, right_high_row, right_mean_row, input ready);
	modport sink   (input valid, column_index, left_low_row, left_high_row, left_mean_row,
		right_low_row, right_high_row, right_mean_row, output ready);

endinterface

@@ rtl/minmax_mean_column_decimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_mean_column_decimator
// Folds each window of 2^window_shift samples into one display column with
// the rows of the minimum, maximum and mean of each channel, up to the view width.
// ----------------------------------------------------------------------------
//  channel  dir  transaction          payload
//  smp      in   valid & ready        left_sample, right_sample, last_sample
//  col      out  valid & ready        column_index, six 13-bit rows
//  cfg      in   cfg_we (no ready)    cfg_index, cfg_data
//
//  A sample that does not close a window leaves smp.ready high.
//  A closing sample waits for the bit-serial mean divider, which runs once
//  per channel (left only in mono, left then right in stereo), and then for
//  the row scaler pipeline.
//  smp.ready is low only while a column is computed or waits for the output
//  register; a held output register stalls only the next closing sample.
//  Reset restores the register defaults and clears all window state.
// ----------------------------------------------------------------------------
module minmax_mean_column_decimator #(
	parameter int SAMPLE_BITS = 32,
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_SHIFT   = 19
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mmcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mmcd_pkg::CFG_DATA_W-1:0] cfg_data,
	mmcd_smp_if.sink                        smp,
	mmcd_col_if.source                      col
);
	import mmcd_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	mmcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mmcd_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_SHIFT   (MAX_SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.smp       (smp),
		.col       (col)
	);

endmodule

@@ rtl/mmcd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_div
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mmcd_div #(
	parameter int NUM_W = 51,
	parameter int DEN_W = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [NUM_W-1:0] d_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fit;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, d_q[NUM_W-1]};
	assign fit   = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			d_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			d_q   <= {d_q[NUM_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? $signed(NUM_W'(-d_q)) : $signed(d_q);

endmodule

@@ rtl/mmcd_row.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_row
// Row scaler: y = h/2 + trunc(trunc(s*h/2) / (2^(SAMPLE_BITS-1) - 1)),
// saturated at zero. Two register stages, result valid after the second.
// ----------------------------------------------------------------------------
module mmcd_row #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          issue,
	input  mmcd_pkg::row_sel_t            tag,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	input  logic [mmcd_pkg::DIM_W-1:0]    height,
	output logic                          res_valid,
	output mmcd_pkg::row_sel_t            res_tag,
	output logic [mmcd_pkg::ROW_W-1:0]    res_row,
	output logic                          busy
);
	import mmcd_pkg::*;

	localparam int K   = SAMPLE_BITS - 1;
	localparam int PW  = SAMPLE_BITS + DIM_W + 1;
	localparam int CW  = ((K > Q_W) ? K : Q_W) + 1;
	localparam int C2W = K + 1;

	logic                 valid_s1;
	row_sel_t             tag_s1;
	logic signed [PW-1:0] prod_s1;

	logic                 valid_s2;
	row_sel_t             tag_s2;
	logic                 neg_s2;
	logic [Q_W-1:0]       q_s2;

	logic [PW-1:0]   mag;
	logic [PW-2:0]   m;
	logic [Q_W-1:0]  a;
	logic [K-1:0]    b;
	logic [CW-1:0]   c;
	logic [CW-K-1:0] c_hi;
	logic [C2W-1:0]  c2;
	logic [Q_W-1:0]  q;
	logic [15:0]     half16;
	logic [15:0]     y;

	assign mag  = prod_s1[PW-1] ? PW'(-prod_s1) : PW'(prod_s1);
	assign m    = mag[PW-1:1];
	assign a    = m[PW-2:K];
	assign b    = m[K-1:0];
	assign c    = CW'(a) + CW'(b);
	assign c_hi = c[CW-1:K];
	assign c2   = C2W'(c_hi) + C2W'(c[K-1:0]);
	assign q    = a + Q_W'(c_hi) + Q_W'(c2 >= C2W'({K{1'b1}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag;
		prod_s1 <= PW'(smp) * PW'($signed({1'b0, height}));
		tag_s2  <= tag_s1;
		neg_s2  <= prod_s1[PW-1];
		q_s2    <= q;
	end

	assign half16 = 16'(height[DIM_W-1:1]);
	assign y      = neg_s2 ? half16 - 16'(q_s2) : half16 + 16'(q_s2);

	assign res_valid = valid_s2;
	assign res_tag   = tag_s2;
	assign res_row   = y[15] ? '0 : y[ROW_W-1:0];
	assign busy      = valid_s1 | valid_s2;

endmodule

@@ rtl/mmcd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_ctrl
// Sequencer: accept samples, then run the mean divides, the row scaler
// and the output load for each closed column.
// ----------------------------------------------------------------------------
module mmcd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  mmcd_pkg::ctrl_sts_t sts,
	output mmcd_pkg::ctrl_cmd_t cmd
);
	import mmcd_pkg::*;

	state_t   state_q;
	state_t   state_nx;
	row_sel_t row_q;
	row_sel_t row_end;

	assign row_end = sts.stereo ? ROW_R_MEAN : ROW_L_MEAN;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:       if (sts.take_close) state_nx = ST_DIV_L_GO;
			ST_DIV_L_GO:   state_nx = ST_DIV_L_WAIT;
			ST_DIV_L_WAIT: if (sts.div_done) state_nx = sts.stereo ? ST_DIV_R_GO : ST_ROWS;
			ST_DIV_R_GO:   state_nx = ST_DIV_R_WAIT;
			ST_DIV_R_WAIT: if (sts.div_done) state_nx = ST_ROWS;
			ST_ROWS:       if (row_q == row_end) state_nx = ST_DRAIN;
			ST_DRAIN:      if (!sts.row_busy) state_nx = ST_LOAD;
			ST_LOAD:       if (sts.out_free) state_nx = ST_IDLE;
			default:       state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.row_sel   = row_q;
		cmd.div_right = (state_q == ST_DIV_R_GO) || (state_q == ST_DIV_R_WAIT);
		unique case (state_q) inside
			ST_IDLE:                  cmd.accept    = 1'b1;
			ST_DIV_L_GO, ST_DIV_R_GO: cmd.div_start = 1'b1;
			ST_ROWS:                  cmd.row_issue = 1'b1;
			ST_LOAD:                  cmd.load_out  = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= ROW_L_LO;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_ROWS && row_q != row_end) begin
				row_q <= row_sel_t'(row_q + 1'b1);
			end else begin
				row_q <= ROW_L_LO;
			end
		end
	end

endmodule

@@ rtl/mmcd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcd_dp
// Datapath: configuration, per-window min/max/sum accumulators, mean
// divider, row scaler and the column output register.
// ----------------------------------------------------------------------------
module mmcd_dp #(
	parameter int SAMPLE_BITS = 32,
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_SHIFT   = 19
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mmcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  mmcd_pkg::ctrl_cmd_t              cmd,
	output mmcd_pkg::ctrl_sts_t              sts,
	mmcd_smp_if.sink                         smp,
	mmcd_col_if.source                       col
);
	import mmcd_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + MAX_SHIFT;
	localparam int CNT_W = MAX_SHIFT + 1;
	localparam int CL_W  = $clog2(MAX_COLUMNS + 1);
	localparam int WW    = (CL_W > COL_CNT_W) ? CL_W : COL_CNT_W;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [SHIFT_W-1:0] shift_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   width_q;
	logic               stereo_q;

	logic signed [SAMPLE_BITS-1:0] lmin_q, lmax_q, rmin_q, rmax_q;
	logic signed [SUM_W-1:0]       lsum_q, rsum_q;
	logic [CNT_W-1:0]              wcnt_q;
	logic [COL_CNT_W-1:0]          ccnt_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] lmean_q, rmean_q;
	logic [ROW_W-1:0]              row_q [6];

	logic                 out_valid_q;
	logic [COL_IDX_W-1:0] col_idx_q;
	logic [ROW_W-1:0]     llo_q, lhi_q, lmn_q, rlo_q, rhi_q, rmn_q;

	logic [SHIFT_W-1:0]            shift_eff;
	logic [DIM_W-1:0]              height_eff;
	logic [WW-1:0]                 width_x;
	logic [WW-1:0]                 width_eff;
	logic [CNT_W-1:0]              win_size;
	logic [CNT_W-1:0]              wcnt_nx;
	logic                          beyond;
	logic                          closes;
	logic                          fire;
	logic signed [SAMPLE_BITS-1:0] ls, rs;

	logic                          div_done;
	logic signed [SUM_W-1:0]       div_quo;
	logic                          rres_valid;
	row_sel_t                      rres_tag;
	logic [ROW_W-1:0]              rres_row;
	logic                          row_busy;
	logic signed [SAMPLE_BITS-1:0] row_opd;

	always_comb begin
		shift_eff = shift_q;
		if (shift_q == '0) begin
			shift_eff = SHIFT_W'(1);
		end else if (shift_q > SHIFT_W'(MAX_SHIFT)) begin
			shift_eff = SHIFT_W'(MAX_SHIFT);
		end
		height_eff = height_q;
		if (height_q < DIM_W'(MIN_VIEW_HEIGHT)) begin
			height_eff = DIM_W'(MIN_VIEW_HEIGHT);
		end else if (height_q > DIM_W'(MAX_VIEW_HEIGHT)) begin
			height_eff = DIM_W'(MAX_VIEW_HEIGHT);
		end
		width_x   = WW'(width_q);
		width_eff = width_x;
		if (width_x < WW'(MIN_VIEW_WIDTH)) begin
			width_eff = WW'(MIN_VIEW_WIDTH);
		end else if (width_x > WW'(MAX_COLUMNS)) begin
			width_eff = WW'(MAX_COLUMNS);
		end
	end

	assign win_size = CNT_W'(1) << shift_eff;
	assign wcnt_nx  = wcnt_q + 1'b1;
	assign beyond   = WW'(ccnt_q) >= width_eff;
	assign closes   = smp.last_sample || (wcnt_nx >= win_size);
	assign fire     = smp.valid && cmd.accept;
	assign ls       = $signed(smp.left_sample[SAMPLE_BITS-1:0]);
	assign rs       = $signed(smp.right_sample[SAMPLE_BITS-1:0]);

	assign smp.ready = cmd.accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= SHIFT_W'(1);
			height_q <= DIM_W'(MIN_VIEW_HEIGHT);
			width_q  <= DIM_W'(MIN_VIEW_WIDTH);
			stereo_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WINDOW_SHIFT: shift_q  <= cfg_data[SHIFT_W-1:0];
				CFG_VIEW_HEIGHT:  height_q <= cfg_data[DIM_W-1:0];
				CFG_VIEW_WIDTH:   width_q  <= cfg_data[DIM_W-1:0];
				CFG_STEREO_MODE:  stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lmin_q <= S_MAX;
			lmax_q <= S_MIN;
			lsum_q <= '0;
			rmin_q <= S_MAX;
			rmax_q <= S_MIN;
			rsum_q <= '0;
			wcnt_q <= '0;
			ccnt_q <= '0;
			last_q <= 1'b0;
		end else if (fire && beyond) begin
			if (smp.last_sample) begin
				lmin_q <= S_MAX;
				lmax_q <= S_MIN;
				lsum_q <= '0;
				rmin_q <= S_MAX;
				rmax_q <= S_MIN;
				rsum_q <= '0;
				wcnt_q <= '0;
				ccnt_q <= '0;
			end
		end else if (fire) begin
			if (ls < lmin_q) lmin_q <= ls;
			if (ls > lmax_q) lmax_q <= ls;
			lsum_q <= lsum_q + SUM_W'(ls);
			if (stereo_q) begin
				if (rs < rmin_q) rmin_q <= rs;
				if (rs > rmax_q) rmax_q <= rs;
				rsum_q <= rsum_q + SUM_W'(rs);
			end
			wcnt_q <= wcnt_nx;
			last_q <= smp.last_sample;
		end else if (cmd.load_out) begin
			lmin_q <= S_MAX;
			lmax_q <= S_MIN;
			lsum_q <= '0;
			rmin_q <= S_MAX;
			rmax_q <= S_MIN;
			rsum_q <= '0;
			wcnt_q <= '0;
			ccnt_q <= last_q ? '0 : ccnt_q + 1'b1;
		end
	end

	mmcd_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_right ? rsum_q : lsum_q),
		.den    (wcnt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (cmd.div_right) begin
				rmean_q <= div_quo[SAMPLE_BITS-1:0];
			end else begin
				lmean_q <= div_quo[SAMPLE_BITS-1:0];
			end
		end
	end

	always_comb begin
		unique case (cmd.row_sel)
			ROW_L_LO:   row_opd = lmin_q;
			ROW_L_HI:   row_opd = lmax_q;
			ROW_L_MEAN: row_opd = lmean_q;
			ROW_R_LO:   row_opd = rmin_q;
			ROW_R_HI:   row_opd = rmax_q;
			ROW_R_MEAN: row_opd = rmean_q;
			default:    row_opd = '0;
		endcase
	end

	mmcd_row #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (cmd.row_issue),
		.tag       (cmd.row_sel),
		.smp       (row_opd),
		.height    (height_eff),
		.res_valid (rres_valid),
		.res_tag   (rres_tag),
		.res_row   (rres_row),
		.busy      (row_busy)
	);

	always_ff @(posedge clk) begin
		if (rres_valid) begin
			unique case (rres_tag)
				ROW_L_LO:   row_q[0] <= rres_row;
				ROW_L_HI:   row_q[1] <= rres_row;
				ROW_L_MEAN: row_q[2] <= rres_row;
				ROW_R_LO:   row_q[3] <= rres_row;
				ROW_R_HI:   row_q[4] <= rres_row;
				ROW_R_MEAN: row_q[5] <= rres_row;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (col.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			col_idx_q <= ccnt_q[COL_IDX_W-1:0];
			llo_q     <= row_q[0];
			lhi_q     <= row_q[1];
			lmn_q     <= row_q[2];
			rlo_q     <= stereo_q ? row_q[3] : '0;
			rhi_q     <= stereo_q ? row_q[4] : '0;
			rmn_q     <= stereo_q ? row_q[5] : '0;
		end
	end

	assign col.valid          = out_valid_q;
	assign col.column_index   = col_idx_q;
	assign col.left_low_row   = llo_q;
	assign col.left_high_row  = lhi_q;
	assign col.left_mean_row  = lmn_q;
	assign col.right_low_row  = rlo_q;
	assign col.right_high_row = rhi_q;
	assign col.right_mean_row = rmn_q;

	assign sts.take_close = fire && !beyond && closes;
	assign sts.div_done   = div_done;
	assign sts.row_busy   = row_busy;
	assign sts.out_free   = !out_valid_q || col.ready;
	assign sts.stereo     = stereo_q;

endmodule
